// ===== src/dwc_pkg.sv =====
// ----------------------------------------------------------------------------
// dwc_pkg: shared types and constants for the depthwise 11-tap convolution
// Sizes of the weight and history stores, field widths, the MAC control
// struct and the round/saturate helper for Q16.20 to Q8.8.
// ----------------------------------------------------------------------------
package dwc_pkg;

    // Block sizing
    localparam int MAX_CHANNELS = 256;
    localparam int TAPS         = 11;
    localparam int HALF         = TAPS / 2;
    localparam int HIST         = TAPS - 1;
    localparam int LAG          = TAPS - 1 - HALF;

    // Fixed field widths
    localparam int CH_W   = 8;
    localparam int CFG_W  = 9;
    localparam int POS_W  = 16;
    localparam int VAL_W  = 16;
    localparam int TAP_W  = 4;
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int FRAC_SHIFT = 12;

    // Store geometry
    localparam int WDEPTH  = MAX_CHANNELS * TAPS;
    localparam int HDEPTH  = MAX_CHANNELS * HIST;
    localparam int WADDR_W = $clog2(WDEPTH);
    localparam int HADDR_W = $clog2(HDEPTH);
    localparam int SLOT_W  = $clog2(HIST);

    // Input opcodes
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Per-tap control traveling with the read data into the MAC
    typedef struct packed {
        logic valid;   // a tap term is present
        logic first;   // first term of a sum: restart the accumulator
        logic use_tap; // term inside the position window, else zero
    } mac_ctl_t;

    // Round half up by 2^11, arithmetic shift by 12, saturate to Q8.8
    function automatic logic signed [VAL_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W:0]            biased;
        logic signed [ACC_W-FRAC_SHIFT:0] shifted;
        logic signed [ACC_W-FRAC_SHIFT:0] max_v;
        logic signed [ACC_W-FRAC_SHIFT:0] min_v;
        biased  = (ACC_W+1)'(acc) + (ACC_W+1)'(1 << (FRAC_SHIFT - 1));
        shifted = biased[ACC_W:FRAC_SHIFT];
        max_v   = (ACC_W-FRAC_SHIFT+1)'((1 << (VAL_W - 1)) - 1);
        min_v   = -(ACC_W-FRAC_SHIFT+1)'(1 << (VAL_W - 1));
        if (shifted > max_v) begin
            round_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (shifted < min_v) begin
            round_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            round_sat = shifted[VAL_W-1:0];
        end
    endfunction

endpackage

// ===== src/dwc_ram.sv =====
// ----------------------------------------------------------------------------
// dwc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/dwc_mac.sv =====
// ----------------------------------------------------------------------------
// dwc_mac: shared multiply-accumulate unit
// One 16x16 product per cycle, registered, then summed into a 36-bit
// accumulator. The rounded and saturated Q8.8 view of the sum is output.
// ----------------------------------------------------------------------------
module dwc_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  dwc_pkg::mac_ctl_t                  ctl,
    input  logic signed [dwc_pkg::VAL_W-1:0]   x,
    input  logic signed [dwc_pkg::VAL_W-1:0]   w,
    output logic signed [dwc_pkg::VAL_W-1:0]   result
);
    import dwc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    mac_ctl_t                 ctl1_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    // Multiply stage: terms outside the window contribute zero
    always_comb begin
        prod_next = ctl.use_tap ? PROD_W'(x * w) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
        end else begin
            ctl1_reg <= ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.valid) begin
            prod_reg <= prod_next;
        end
    end

    // Accumulate stage
    always_comb begin
        acc_next = (ctl1_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctl1_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign result = round_sat(acc_reg);

endmodule

// ===== src/depthwise_conv1d_11tap.sv =====
// ----------------------------------------------------------------------------
// depthwise_conv1d_11tap: per-channel centered 11-tap convolution
// Streams Q8.8 samples channel by channel and emits Q8.8 results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): opcode 0 loads one Q4.12 weight (channel, tap);
//   opcode 1 supplies one Q8.8 sample. Samples come in channel order within
//   a position; s_sequence_start marks position zero of a new sequence.
//   Result channel (m_*): the result for position p-5 and the sample's
//   channel, emitted once position 5 is reached. Feed 5 zero positions at
//   the end of a sequence to flush the last results.
//   cfg_wr_en/cfg_wr_data set the channel count (0 acts as 1, above 256 as
//   256); write it only while the block is idle.
//   Sequence: a weight load is written straight to the weight RAM. A
//   sample runs one read of the weight and history RAMs per tap through
//   the one shared MAC, drains the RAM, product and accumulate registers,
//   writes back and returns to idle, where the next transfer is taken.
//   Samples for unused channels are dropped.
//   Reset clears the position count and sets the channel count to 160; the
//   weight and history RAMs hold whatever they held until written.
//   The result sits in an output register; a stalled receiver holds the
//   block in its write-back cycle only when a second result is ready.
// ----------------------------------------------------------------------------
module depthwise_conv1d_11tap (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [dwc_pkg::CFG_W-1:0]         cfg_wr_data,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [dwc_pkg::CH_W-1:0]          s_channel,
    input  logic [dwc_pkg::TAP_W-1:0]         s_tap,
    input  logic signed [dwc_pkg::VAL_W-1:0]  s_value,
    input  logic                              s_sequence_start,
    // results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [dwc_pkg::CH_W-1:0]          m_out_channel,
    output logic [dwc_pkg::POS_W-1:0]         m_out_position,
    output logic signed [dwc_pkg::VAL_W-1:0]  m_out_value
);
    import dwc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CFG_W-1:0]          chan_cfg_reg, chan_cfg_next;
    logic [CFG_W-1:0]          eff_ch;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [SLOT_W-1:0]         pmod_reg, pmod_next;
    // latched sample
    logic [CH_W-1:0]           ch_reg, ch_next;
    logic signed [VAL_W-1:0]   val_reg, val_next;
    logic [POS_W-1:0]          p_reg, p_next;
    logic [SLOT_W-1:0]         pslot_reg, pslot_next;
    logic [WADDR_W-1:0]        wbase_reg, wbase_next;
    logic [HADDR_W-1:0]        hbase_reg, hbase_next;
    // tap sequencer
    logic [TAP_W-1:0]          tap_reg, tap_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic                      drain_reg, drain_next;
    mac_ctl_t                  ctl0, ctl_d_reg;
    logic                      cur_d_reg, cur_d_next;
    // output register
    logic                      m_valid_reg, m_valid_next;
    logic [CH_W-1:0]           m_ch_reg, m_ch_next;
    logic [POS_W-1:0]          m_pos_reg, m_pos_next;
    logic signed [VAL_W-1:0]   m_val_reg, m_val_next;

    logic                      in_xfer;
    logic                      wt_we;
    logic [WADDR_W-1:0]        wt_waddr;
    logic [WADDR_W-1:0]        wt_raddr;
    logic [VAL_W-1:0]          wt_rdata;
    logic                      hist_we;
    logic [HADDR_W-1:0]        hist_waddr;
    logic [HADDR_W-1:0]        hist_raddr;
    logic [VAL_W-1:0]          hist_rdata;
    logic signed [VAL_W-1:0]   mac_x;
    logic signed [VAL_W-1:0]   mac_result;
    logic                      produce;
    logic                      out_free;
    logic                      done_go;
    logic                      last_ch;
    logic                      in_window;

    // Effective channel count
    always_comb begin
        if (chan_cfg_reg == '0) begin
            eff_ch = CFG_W'(1);
        end else if (chan_cfg_reg > CFG_W'(MAX_CHANNELS)) begin
            eff_ch = CFG_W'(MAX_CHANNELS);
        end else begin
            eff_ch = chan_cfg_reg;
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign produce  = (p_reg >= POS_W'(LAG));
    assign out_free = !m_valid_reg || m_ready;
    assign done_go  = (state_reg == ST_DONE) && (out_free || !produce);
    assign last_ch  = ({1'b0, ch_reg} == eff_ch - CFG_W'(1));

    // Weight loads go straight to the weight RAM
    assign wt_we    = in_xfer && (s_opcode == OP_WEIGHT) &&
                      ({1'b0, s_channel} < CFG_W'(MAX_CHANNELS)) &&
                      (s_tap < TAP_W'(TAPS));
    assign wt_waddr = WADDR_W'(WADDR_W'(s_channel) * WADDR_W'(TAPS)) + WADDR_W'(s_tap);
    assign wt_raddr = wbase_reg + WADDR_W'(tap_reg);

    // History: read one slot per tap, write the new sample at the end
    assign hist_raddr = hbase_reg + HADDR_W'(slot_reg);
    assign hist_we    = done_go;
    assign hist_waddr = hbase_reg + HADDR_W'(pslot_reg);

    // Tap j reaches back to position p-HIST+j, which must not precede zero
    assign in_window = (p_reg >= POS_W'(HIST)) ||
                       ((TAP_W+1)'(p_reg[TAP_W-1:0]) + (TAP_W+1)'(tap_reg)
                        >= (TAP_W+1)'(HIST));

    always_comb begin
        ctl0.valid   = (state_reg == ST_RUN);
        ctl0.first   = (tap_reg == '0);
        ctl0.use_tap = (tap_reg == TAP_W'(TAPS - 1)) || in_window;
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        chan_cfg_next = cfg_wr_en ? cfg_wr_data : chan_cfg_reg;
        pos_next      = pos_reg;
        pmod_next     = pmod_reg;
        ch_next       = ch_reg;
        val_next      = val_reg;
        p_next        = p_reg;
        pslot_next    = pslot_reg;
        wbase_next    = wbase_reg;
        hbase_next    = hbase_reg;
        tap_next      = tap_reg;
        slot_next     = slot_reg;
        drain_next    = drain_reg;
        cur_d_next    = (state_reg == ST_RUN) && (tap_reg == TAP_W'(TAPS - 1));
        m_valid_next  = m_valid_reg && !m_ready;
        m_ch_next     = m_ch_reg;
        m_pos_next    = m_pos_reg;
        m_val_next    = m_val_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && (s_opcode == OP_SAMPLE) && ({1'b0, s_channel} < eff_ch)) begin
                    ch_next    = s_channel;
                    val_next   = s_value;
                    p_next     = s_sequence_start ? '0 : pos_reg;
                    pslot_next = s_sequence_start ? '0 : pmod_reg;
                    slot_next  = s_sequence_start ? '0 : pmod_reg;
                    wbase_next = WADDR_W'(WADDR_W'(s_channel) * WADDR_W'(TAPS));
                    hbase_next = HADDR_W'(HADDR_W'(s_channel) * HADDR_W'(HIST));
                    tap_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                tap_next  = tap_reg + TAP_W'(1);
                slot_next = (slot_reg == SLOT_W'(HIST - 1)) ? '0 : slot_reg + SLOT_W'(1);
                if (tap_reg == TAP_W'(TAPS - 1)) begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait out RAM read, product and accumulate registers
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (done_go) begin
                    if (produce) begin
                        m_valid_next = 1'b1;
                        m_ch_next    = ch_reg;
                        m_pos_next   = p_reg - POS_W'(LAG);
                        m_val_next   = mac_result;
                    end
                    if (last_ch) begin
                        pos_next  = p_reg + POS_W'(1);
                        pmod_next = ((p_reg == '1) || (pslot_reg == SLOT_W'(HIST - 1))) ?
                                    '0 : pslot_reg + SLOT_W'(1);
                    end else begin
                        pos_next  = p_reg;
                        pmod_next = pslot_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            chan_cfg_reg <= CFG_W'(160);
            pos_reg      <= '0;
            pmod_reg     <= '0;
            tap_reg      <= '0;
            slot_reg     <= '0;
            drain_reg    <= 1'b0;
            ctl_d_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            chan_cfg_reg <= chan_cfg_next;
            pos_reg      <= pos_next;
            pmod_reg     <= pmod_next;
            tap_reg      <= tap_next;
            slot_reg     <= slot_next;
            drain_reg    <= drain_next;
            ctl_d_reg    <= ctl0;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ch_reg    <= ch_next;
        val_reg   <= val_next;
        p_reg     <= p_next;
        pslot_reg <= pslot_next;
        wbase_reg <= wbase_next;
        hbase_reg <= hbase_next;
        cur_d_reg <= cur_d_next;
        m_ch_reg  <= m_ch_next;
        m_pos_reg <= m_pos_next;
        m_val_reg <= m_val_next;
    end

    // Stores
    dwc_ram #(.WIDTH(VAL_W), .DEPTH(WDEPTH)) u_weight_ram (
        .aclk    (aclk),
        .wr_en   (wt_we),
        .wr_addr (wt_waddr),
        .wr_data (s_value),
        .rd_addr (wt_raddr),
        .rd_data (wt_rdata)
    );

    dwc_ram #(.WIDTH(VAL_W), .DEPTH(HDEPTH)) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (hist_we),
        .wr_addr (hist_waddr),
        .wr_data (val_reg),
        .rd_addr (hist_raddr),
        .rd_data (hist_rdata)
    );

    // Newest tap uses the incoming sample itself
    assign mac_x = cur_d_reg ? val_reg : signed'(hist_rdata);

    dwc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl_d_reg),
        .x       (mac_x),
        .w       (signed'(wt_rdata)),
        .result  (mac_result)
    );

    assign m_valid        = m_valid_reg;
    assign m_out_channel  = m_ch_reg;
    assign m_out_position = m_pos_reg;
    assign m_out_value    = m_val_reg;

    // Checks
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside write-back");

    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (tap_reg < TAP_W'(TAPS)))
        else $error("tap counter out of range");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pmod_reg < SLOT_W'(HIST)) && (slot_reg < SLOT_W'(HIST)))
        else $error("history slot out of range");

    a_done_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        done_go |=> (state_reg == ST_IDLE))
        else $error("write-back did not return to idle");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_val_reg)))
        else $error("pending result overwritten");

endmodule
